[design/rsk_pkg.sv]
package rsk_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int PASS_W      = $clog2(MAX_RECORDS);
  localparam int TAG_W       = 8;
  localparam int SCORE_W     = 10;
  localparam int KEY_W       = SCORE_W + 2;
  localparam int SEL_W       = 2;

  // sort key selections
  localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SECOND = 2'd1;
  localparam logic [SEL_W-1:0] SEL_THIRD  = 2'd2;
  localparam logic [SEL_W-1:0] SEL_SUM    = 2'd3;

  // cell commands
  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_SORT  = 2'd2;
  localparam logic [1:0] CMD_SHIFT = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]   record_tag;
    logic [SCORE_W-1:0] score_first;
    logic [SCORE_W-1:0] score_second;
    logic [SCORE_W-1:0] score_third;
    logic               final_record;
  } in_rec_t;

  typedef struct packed {
    logic [TAG_W-1:0]   out_tag;
    logic [SCORE_W-1:0] out_first;
    logic [SCORE_W-1:0] out_second;
    logic [SCORE_W-1:0] out_third;
    logic               out_last;
    logic               overflow;
  } out_rec_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] s1;
    logic [SCORE_W-1:0] s2;
    logic [SCORE_W-1:0] s3;
  } rec_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SEL_W-1:0] sort_key;
  } cell_ctl_t;

  function automatic logic [KEY_W-1:0] key_of(input rec_t r, input logic [SEL_W-1:0] sel);
    logic [KEY_W-1:0] k;
    begin
      unique case (sel)
        SEL_FIRST:  k = KEY_W'(r.s1);
        SEL_SECOND: k = KEY_W'(r.s2);
        SEL_THIRD:  k = KEY_W'(r.s3);
        SEL_SUM:    k = KEY_W'(r.s1) + KEY_W'(r.s2) + KEY_W'(r.s3);
        default:    k = KEY_W'(r.s1);
      endcase
      return k;
    end
  endfunction

endpackage

[design/rsk_cell.sv]
module rsk_cell (
  input  logic                clk,
  input  rsk_pkg::cell_ctl_t  ctl,
  input  logic                load_en,
  input  rsk_pkg::rec_t       load_rec,
  input  logic                pair_left,
  input  logic                pair_right,
  input  rsk_pkg::rec_t       left_rec,
  input  rsk_pkg::rec_t       right_rec,
  output rsk_pkg::rec_t       rec_q
);

  rsk_pkg::rec_t rec_r;
  rsk_pkg::rec_t rec_nxt;
  logic [rsk_pkg::KEY_W-1:0] own_key;
  logic [rsk_pkg::KEY_W-1:0] left_key;
  logic [rsk_pkg::KEY_W-1:0] right_key;

  assign own_key   = rsk_pkg::key_of(rec_r, ctl.sort_key);
  assign left_key  = rsk_pkg::key_of(left_rec, ctl.sort_key);
  assign right_key = rsk_pkg::key_of(right_rec, ctl.sort_key);

  // exchange only on strictly smaller key ahead, which keeps equal keys in order
  always_comb begin
    rec_nxt = rec_r;
    unique case (ctl.cmd)
      rsk_pkg::CMD_LOAD: begin
        if (load_en) rec_nxt = load_rec;
      end
      rsk_pkg::CMD_SORT: begin
        if (pair_left && (own_key < right_key)) begin
          rec_nxt = right_rec;
        end else if (pair_right && (left_key < own_key)) begin
          rec_nxt = left_rec;
        end
      end
      rsk_pkg::CMD_SHIFT: rec_nxt = right_rec;
      default:            rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_q = rec_r;

endmodule

[design/record_sort_by_key.sv]
// Stable descending record sorter.
// Input channel (in_valid, in_stall, in_data): one record per request. A record
// marked final_record closes the set; in_stall then stays high until the sorted
// run has been handed to the output register.
// Result channel (out_valid, out_stall, out_data): the stored records in
// descending order of the selected key, equal keys in arrival order, out_last
// on the final one and overflow on every result of a set that lost records.
// Config channel (cfg_valid, cfg_ready, cfg_data): sort_key, always ready.
// Records load at one per cycle into a chain of MAX_RECORDS cells. After the
// final record the chain runs MAX_RECORDS odd-even exchange passes (one per
// cycle), then drains one record per cycle from the head cell whenever the
// output register is empty or out_stall is low.
// When out_stall is high and a result is held, the output register keeps it and
// the drain pauses. Records beyond MAX_RECORDS are dropped.
// Synchronous reset clears the record count, the dropped flag, sort_key and the
// output valid; no clearing pass is needed.
module record_sort_by_key (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rsk_pkg::in_rec_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rsk_pkg::out_rec_t      out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [rsk_pkg::SEL_W-1:0] cfg_data
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SORT  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [rsk_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [rsk_pkg::PASS_W-1:0]  pass_r, pass_nxt;
  logic                        dropped_r, dropped_nxt;
  logic [rsk_pkg::SEL_W-1:0]   sort_key_r;
  logic                        out_valid_r, out_valid_nxt;
  rsk_pkg::out_rec_t           out_data_r, out_data_nxt;

  rsk_pkg::cell_ctl_t          ctl;
  rsk_pkg::rec_t               load_rec;
  rsk_pkg::rec_t               cell_rec [rsk_pkg::MAX_RECORDS];
  logic                        in_accept;
  logic                        store_ok;
  logic                        emit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign store_ok  = (count_r < rsk_pkg::CNT_W'(rsk_pkg::MAX_RECORDS));
  assign emit      = (state_r == ST_DRAIN) && (count_r != '0) && (!out_valid_r || !out_stall);

  assign load_rec.tag = in_data.record_tag;
  assign load_rec.s1  = in_data.score_first;
  assign load_rec.s2  = in_data.score_second;
  assign load_rec.s3  = in_data.score_third;

  always_comb begin
    ctl.sort_key = sort_key_r;
    if (in_accept && store_ok) begin
      ctl.cmd = rsk_pkg::CMD_LOAD;
    end else if (state_r == ST_SORT) begin
      ctl.cmd = rsk_pkg::CMD_SORT;
    end else if (emit) begin
      ctl.cmd = rsk_pkg::CMD_SHIFT;
    end else begin
      ctl.cmd = rsk_pkg::CMD_HOLD;
    end
  end

  for (genvar i = 0; i < rsk_pkg::MAX_RECORDS; i++) begin : g_cell
    localparam logic PAR_L = 1'(i % 2);
    localparam logic PAR_R = 1'((i + 1) % 2);
    logic          pair_left;
    logic          pair_right;
    rsk_pkg::rec_t left_rec;
    rsk_pkg::rec_t right_rec;

    // pairs start at even cells on even passes, at odd cells on odd passes
    assign pair_left  = (pass_r[0] == PAR_L) &&
                        (count_r > rsk_pkg::CNT_W'(i + 1));
    assign pair_right = (i > 0) && (pass_r[0] == PAR_R) &&
                        (count_r > rsk_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_rec = cell_rec[i];
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
    end
    if (i == rsk_pkg::MAX_RECORDS - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    rsk_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_en    (count_r == rsk_pkg::CNT_W'(i)),
      .load_rec   (load_rec),
      .pair_left  (pair_left),
      .pair_right (pair_right),
      .left_rec   (left_rec),
      .right_rec  (right_rec),
      .rec_q      (cell_rec[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pass_nxt      = pass_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          if (store_ok) begin
            count_nxt = count_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.final_record) begin
            state_nxt = ST_SORT;
            pass_nxt  = '0;
          end
        end
      end
      ST_SORT: begin
        pass_nxt = pass_r + 1'b1;
        if (pass_r == rsk_pkg::PASS_W'(rsk_pkg::MAX_RECORDS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (emit) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_tag    = cell_rec[0].tag;
          out_data_nxt.out_first  = cell_rec[0].s1;
          out_data_nxt.out_second = cell_rec[0].s2;
          out_data_nxt.out_third  = cell_rec[0].s3;
          out_data_nxt.out_last   = (count_r == rsk_pkg::CNT_W'(1));
          out_data_nxt.overflow   = dropped_r;
          count_nxt               = count_r - 1'b1;
          if (count_r == rsk_pkg::CNT_W'(1)) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      pass_r      <= '0;
      dropped_r   <= 1'b0;
      sort_key_r  <= rsk_pkg::SEL_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pass_r      <= pass_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) sort_key_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/tb.sv]
module tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 2 * rsk_pkg::MAX_RECORDS + 8;
  localparam int RANDOM_ITEMS  = 240;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rsk_pkg::in_rec_t  in_data;
  logic              out_valid;
  logic              out_stall;
  rsk_pkg::out_rec_t out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [rsk_pkg::SEL_W-1:0] cfg_data;

  record_sort_by_key i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    bit                        wr_key;
    logic [rsk_pkg::SEL_W-1:0] key;
    rsk_pkg::in_rec_t          rec;
    bit                        typed;
    rsk_pkg::out_rec_t         sorted;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // predictor state
  rsk_pkg::in_rec_t          held_recs[$];
  bit                        lost_flag;
  logic [rsk_pkg::SEL_W-1:0] key_sel;
  rsk_pkg::out_rec_t         sorted_q[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned results_checked;
  int unsigned records_sent;
  int unsigned sets_done;
  int unsigned sets_lost;
  int unsigned key_sets[4];
  int unsigned burst_left;

  int unsigned stall_span;
  int unsigned stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycles, sorted_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: stall pattern changes mode whenever stall_span runs out
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(20, 80);
      end
      stall_span--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 4) < 3);
        default: out_stall <= ((stall_span % 7) < 4);
      endcase
    end
  end

  function automatic logic [rsk_pkg::SCORE_W+1:0] sort_value(
      input rsk_pkg::in_rec_t r, input logic [rsk_pkg::SEL_W-1:0] sel);
    logic [rsk_pkg::SCORE_W+1:0] v;
    case (sel)
      rsk_pkg::SEL_FIRST:  v = {2'b00, r.score_first};
      rsk_pkg::SEL_SECOND: v = {2'b00, r.score_second};
      rsk_pkg::SEL_THIRD:  v = {2'b00, r.score_third};
      default:             v = {2'b00, r.score_first} + {2'b00, r.score_second}
                               + {2'b00, r.score_third};
    endcase
    return v;
  endfunction

  // store one accepted request (or flag it lost when full); on the final one queue the sorted run
  task automatic predict_sorted_run(input rsk_pkg::in_rec_t r, input bit typed,
                                    input rsk_pkg::out_rec_t given);
    rsk_pkg::in_rec_t  ranked[$];
    rsk_pkg::out_rec_t o;
    int                j;
    if (held_recs.size() < rsk_pkg::MAX_RECORDS) held_recs.push_back(r);
    else lost_flag = 1'b1;
    if (!r.final_record) return;
    foreach (held_recs[i]) begin
      j = ranked.size();
      // move ahead only past strictly smaller keys
      while (j > 0 && sort_value(ranked[j-1], key_sel) < sort_value(held_recs[i], key_sel))
        j--;
      ranked.insert(j, held_recs[i]);
    end
    foreach (ranked[i]) begin
      o.out_tag    = ranked[i].record_tag;
      o.out_first  = ranked[i].score_first;
      o.out_second = ranked[i].score_second;
      o.out_third  = ranked[i].score_third;
      o.out_last   = (i == ranked.size() - 1);
      o.overflow   = lost_flag;
      sorted_q.push_back(typed ? given : o);
    end
    sets_done++;
    if (lost_flag) sets_lost++;
    key_sets[key_sel]++;
    held_recs.delete();
    lost_flag = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsk_pkg::out_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        check_field("out_tag",    32'(want.out_tag),    32'(out_data.out_tag));
        check_field("out_first",  32'(want.out_first),  32'(out_data.out_first));
        check_field("out_second", 32'(want.out_second), 32'(out_data.out_second));
        check_field("out_third",  32'(want.out_third),  32'(out_data.out_third));
        check_field("out_last",   32'(want.out_last),   32'(out_data.out_last));
        check_field("overflow",   32'(want.overflow),   32'(out_data.overflow));
        results_checked++;
      end
    end
  end

  task automatic send_record(input rsk_pkg::in_rec_t r, input bit typed,
                             input rsk_pkg::out_rec_t given);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    records_sent++;
    predict_sorted_run(r, typed, given);
  endtask

  // hold the sender until every queued result is out and the chain is empty
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_sort_key(input logic [rsk_pkg::SEL_W-1:0] k);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    key_sel = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input bit wr, input logic [rsk_pkg::SEL_W-1:0] k,
                         input rsk_pkg::in_rec_t r, input bit typed,
                         input rsk_pkg::out_rec_t given);
    dir_row_t row;
    row.wr_key = wr;
    row.key    = k;
    row.rec    = r;
    row.typed  = typed;
    row.sorted = given;
    dir_rows.push_back(row);
  endtask

  function automatic logic [rsk_pkg::SCORE_W-1:0] pick_score(input int unsigned mode);
    logic [rsk_pkg::SCORE_W-1:0] corner[5];
    corner = '{10'd0, 10'd1, 10'd512, 10'd1022, 10'd1023};
    case (mode)
      0: return rsk_pkg::SCORE_W'($urandom_range(0, 1023));
      1: return corner[$urandom_range(0, 4)];
      default: return rsk_pkg::SCORE_W'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    rsk_pkg::in_rec_t          r;
    int unsigned               set_len;
    int unsigned               mode;
    int unsigned               sets_left;
    int unsigned               phase;
    int unsigned               pick;
    logic [rsk_pkg::SEL_W-1:0] key_order[4];

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    key_sel    = rsk_pkg::SEL_FIRST;
    lost_flag  = 1'b0;
    burst_left = 0;
    key_order  = '{rsk_pkg::SEL_THIRD, rsk_pkg::SEL_FIRST, rsk_pkg::SEL_SUM,
                   rsk_pkg::SEL_SECOND};

    // single all-ones record under the sum key, then a single all-zero one
    add_row(1, rsk_pkg::SEL_SUM,
            rsk_pkg::in_rec_t'({8'hFF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1}),
            1, rsk_pkg::out_rec_t'({8'hFF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b0}));
    add_row(1, rsk_pkg::SEL_FIRST,
            rsk_pkg::in_rec_t'({8'h00, 10'h000, 10'h000, 10'h000, 1'b1}),
            1, rsk_pkg::out_rec_t'({8'h00, 10'h000, 10'h000, 10'h000, 1'b1, 1'b0}));
    // seventeen records with many ties: the final one is dropped, all flag overflow
    for (int i = 0; i < rsk_pkg::MAX_RECORDS + 1; i++) begin
      r.record_tag   = rsk_pkg::TAG_W'(8'h10 + i);
      r.score_first  = rsk_pkg::SCORE_W'(10'h3FF - i);
      r.score_second = (i % 3 == 0) ? 10'd0 : ((i % 3 == 1) ? 10'd1023 : 10'd512);
      r.score_third  = rsk_pkg::SCORE_W'(i);
      r.final_record = (i == rsk_pkg::MAX_RECORDS);
      add_row(i == 0, rsk_pkg::SEL_SECOND, r, 0, '0);
    end
    // all third scores equal: arrival order must survive
    for (int i = 0; i < 4; i++) begin
      r.record_tag   = rsk_pkg::TAG_W'(8'hA0 + i);
      r.score_first  = rsk_pkg::SCORE_W'(1023 - 100 * i);
      r.score_second = rsk_pkg::SCORE_W'(100 * i);
      r.score_third  = 10'd700;
      r.final_record = (i == 3);
      add_row(i == 0, rsk_pkg::SEL_THIRD, r, 0, '0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_key) write_sort_key(dir_rows[i].key);
      send_record(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].sorted);
    end

    phase     = 0;
    sets_left = 0;
    while (records_sent < dir_rows.size() + RANDOM_ITEMS) begin
      if (sets_left == 0) begin
        write_sort_key(phase < 4 ? key_order[phase]
                                 : rsk_pkg::SEL_W'($urandom_range(0, 3)));
        phase++;
        sets_left = $urandom_range(2, 5);
      end
      sets_left--;
      pick = $urandom_range(0, 19);
      if (pick < 2)        set_len = 1;
      else if (pick < 18)  set_len = $urandom_range(2, rsk_pkg::MAX_RECORDS);
      else                 set_len = $urandom_range(rsk_pkg::MAX_RECORDS + 1,
                                                    rsk_pkg::MAX_RECORDS + 4);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < set_len; i++) begin
        r.record_tag   = rsk_pkg::TAG_W'($urandom_range(0, 255));
        r.score_first  = pick_score(mode);
        r.score_second = pick_score(mode);
        r.score_third  = pick_score(mode);
        r.final_record = (i == set_len - 1);
        send_record(r, 0, '0);
      end
    end

    wait_drained();
    $display("Sent %0d records in %0d sets (%0d with dropped records), checked %0d results.",
             records_sent, sets_done, sets_lost, results_checked);
    $display("Sets per key: first %0d, second %0d, third %0d, sum %0d.",
             key_sets[rsk_pkg::SEL_FIRST], key_sets[rsk_pkg::SEL_SECOND],
             key_sets[rsk_pkg::SEL_THIRD], key_sets[rsk_pkg::SEL_SUM]);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
